// ----- rtl/bal_pkg.sv -----
// ----------------------------------------------------------------------------
// bal_pkg
// Shared types and constants for the bounded array list core and its cells.
// ----------------------------------------------------------------------------
package bal_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    // request codes
    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_APPEND    = 3'd1,
        OP_FIND      = 3'd2,
        OP_READ      = 3'd3,
        OP_REMOVE    = 3'd4
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_BAD_POS   = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } fsm_t;

    typedef struct packed {
        logic [2:0]                  op;
        logic signed [WORD_BITS-1:0] value;
        logic [4:0]                  position;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                  status;
        logic [4:0]                  found_index;
        logic signed [WORD_BITS-1:0] read_data;
        logic [4:0]                  count;
        logic                        empty_res;
    } out_item_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic                 cmp_en;
        logic [WORD_BITS-1:0] cmp_value;
        logic                 shift_in;
        logic                 append;
        logic                 remove;
        logic [WORD_BITS-1:0] wr_value;
        logic [CNT_BITS-1:0]  count;
    } cell_ctl_t;

endpackage

// ----- rtl/bal_cell.sv -----
// ----------------------------------------------------------------------------
// bal_cell
// One list slot: holds a word, compares it against the request value and
// takes its neighbor's word when the list shifts.
// ----------------------------------------------------------------------------
module bal_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bal_pkg::cell_ctl_t           ctl,
    input  logic [bal_pkg::IDX_BITS-1:0] idx,
    input  logic [bal_pkg::WORD_BITS-1:0] prev_word,
    input  logic [bal_pkg::WORD_BITS-1:0] next_word,
    input  logic                         seen_in,
    output logic [bal_pkg::WORD_BITS-1:0] word,
    output logic                         seen_out,
    output logic                         first
);
    import bal_pkg::*;

    logic [WORD_BITS-1:0] word_reg;
    logic                 match_reg;
    logic                 valid;

    // slot holds a live entry when it lies below the count
    assign valid = ({1'b0, idx} < ctl.count) ? 1'b1 : 1'b0;

    // registered compare against the incoming item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else if (ctl.cmp_en) begin
            match_reg <= valid && (word_reg == ctl.cmp_value);
        end
    end

    // first-match chain toward the tail
    assign first    = match_reg && !seen_in;
    assign seen_out = match_reg || seen_in;

    // word update: shift back, append at the tail slot, or close a gap
    always_ff @(posedge aclk) begin
        if (ctl.shift_in) begin
            word_reg <= prev_word;
        end else if (ctl.append && ({1'b0, idx} == ctl.count)) begin
            word_reg <= ctl.wr_value;
        end else if (ctl.remove && seen_out) begin
            word_reg <= next_word;
        end
    end

    assign word = word_reg;

endmodule

// ----- rtl/bounded_array_list_core.sv -----
// ----------------------------------------------------------------------------
// bounded_array_list_core
// Ordered list of signed words in a chain of cells with insert, append,
// find, read and remove requests.
// ----------------------------------------------------------------------------
// An accepted item moves the sequencer to its execute state, which registers the
// result once the output is free; no new item is taken until then. The cells
// register their compare on accept; the first-match chain and shift run in execute.
// Reset clears the count, the sequencer and the output valid; the cell words
// are not cleared and only slots below the count are ever observed.
module bounded_array_list_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bal_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output bal_pkg::out_item_t  m_item
);
    import bal_pkg::*;

    fsm_t                state_reg, state_next;
    in_item_t            item_reg;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                m_valid_reg;
    out_item_t           m_item_reg, m_item_next;
    logic                commit;
    cell_ctl_t           ctl;

    logic [WORD_BITS-1:0] words [DEPTH];
    logic [DEPTH:0]       seen;
    logic [DEPTH-1:0]     first;
    logic [CNT_BITS-1:0]  hit_index;
    logic                 found;
    logic                 full;
    logic [4:0]           pos_m1;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    assign full  = (count_reg == CNT_BITS'(DEPTH));
    // any match carries through to the end of the chain
    assign found = seen[DEPTH];

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
        if (commit) begin
            m_item_reg <= m_item_next;
        end
    end

    // next state and result
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        commit      = 1'b0;
        m_item_next = '0;
        pos_m1      = item_reg.position - 5'd1;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    commit     = 1'b1;
                    state_next = S_IDLE;
                    m_item_next.status = STAT_OK;
                    case (item_reg.op) inside
                        OP_INS_FRONT, OP_APPEND: begin
                            if (full) begin
                                m_item_next.status = STAT_FULL;
                            end else begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_FIND, OP_REMOVE: begin
                            if (!found) begin
                                m_item_next.status = STAT_NOT_FOUND;
                            end else begin
                                m_item_next.found_index = 5'(hit_index);
                                if (item_reg.op == OP_REMOVE) begin
                                    count_next = count_reg - 1'b1;
                                end
                            end
                        end
                        OP_READ: begin
                            if (item_reg.position == 5'd0 ||
                                item_reg.position > 5'(count_reg)) begin
                                m_item_next.status = STAT_BAD_POS;
                            end else begin
                                m_item_next.read_data = words[pos_m1[IDX_BITS-1:0]];
                            end
                        end
                        default: begin
                        end
                    endcase
                    m_item_next.count     = 5'(count_next);
                    m_item_next.empty_res = (count_next == '0);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control broadcast to the cells
    always_comb begin
        ctl.cmp_en    = s_valid && s_ready;
        ctl.cmp_value = s_item.value;
        ctl.shift_in  = commit && (item_reg.op == OP_INS_FRONT) && !full;
        ctl.append    = commit && (item_reg.op == OP_APPEND) && !full;
        ctl.remove    = commit && (item_reg.op == OP_REMOVE);
        ctl.wr_value  = item_reg.value;
        ctl.count     = count_reg;
    end

    // 1-based index of the first matching cell
    always_comb begin
        hit_index = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first[i]) begin
                hit_index = hit_index | CNT_BITS'(i + 1);
            end
        end
    end

    assign seen[0] = 1'b0;

    // the cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_BITS-1:0] prev_w;
        logic [WORD_BITS-1:0] next_w;

        if (g == 0) begin : g_head
            assign prev_w = item_reg.value;
        end else begin : g_mid
            assign prev_w = words[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign next_w = words[g];
        end else begin : g_body
            assign next_w = words[g+1];
        end

        bal_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .idx       (IDX_BITS'(g)),
            .prev_word (prev_w),
            .next_word (next_w),
            .seen_in   (seen[g]),
            .word      (words[g]),
            .seen_out  (seen[g+1]),
            .first     (first[g])
        );
    end

endmodule

// ----- tb/sv/bounded_array_list_core_test.sv -----
// ----------------------------------------------------------------------------
// bounded_array_list_core_test
// Self-checking bench for the bounded array list core. A software copy of the
// list predicts every result at the moment its item is accepted, and a
// monitor compares each result field by field in order. Directed cases cover
// the empty, full and out-of-range corners; random phases push the list
// between empty and full under random gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_array_list_core_test;

    import bal_pkg::*;

    localparam logic [2:0] FIRST_UNUSED_OP = 3'd5;
    localparam logic [2:0] LAST_UNUSED_OP  = 3'd7;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int SETTLE_CYCLES   = 4;
    localparam int MAX_REPORTS     = 10;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_item;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_item;

    // software copy of the list
    logic [WORD_BITS-1:0] list_words [DEPTH];
    int                   list_len = 0;

    out_item_t expected_results [$];
    int        error_count  = 0;
    int        report_count = 0;

    bit gaps_on      = 1'b1;
    bit ready_idling = 1'b1;
    bit hold_off_req = 1'b0;

    bounded_array_list_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #5 aclk = ~aclk;

    // apply one request to the list copy and return its result
    function automatic out_item_t apply_list_request(input in_item_t req);
        out_item_t res;
        int        hit;
        int        i;
        res = '0;
        hit = -1;
        case (req.op) inside
            OP_INS_FRONT, OP_APPEND: begin
                if (list_len >= DEPTH) begin
                    res.status = STAT_FULL;
                end else if (req.op == OP_INS_FRONT) begin
                    for (i = list_len; i > 0; i--)
                        list_words[i] = list_words[i-1];
                    list_words[0] = req.value;
                    list_len++;
                end else begin
                    list_words[list_len] = req.value;
                    list_len++;
                end
            end
            OP_FIND, OP_REMOVE: begin
                for (i = 0; i < list_len; i++)
                    if (hit < 0 && list_words[i] == req.value)
                        hit = i;
                if (hit < 0) begin
                    res.status = STAT_NOT_FOUND;
                end else begin
                    res.found_index = 5'(hit + 1);
                    if (req.op == OP_REMOVE) begin
                        for (i = hit; i + 1 < list_len; i++)
                            list_words[i] = list_words[i+1];
                        list_len--;
                    end
                end
            end
            OP_READ: begin
                if (req.position == 0 || req.position > list_len)
                    res.status = STAT_BAD_POS;
                else
                    res.read_data = list_words[req.position-1];
            end
            default: begin
                // unused codes leave the list alone
            end
        endcase
        res.count     = 5'(list_len);
        res.empty_res = (list_len == 0);
        return res;
    endfunction

    // idle length before an item: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // offer one item and wait for it to be taken
    task automatic send_item(input logic [2:0] op, input logic [WORD_BITS-1:0] value,
                             input logic [4:0] position);
        in_item_t req;
        int       gap;
        req.op       = op;
        req.value    = value;
        req.position = position;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= req;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(apply_list_request(req));
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // word to use: often one already in the list, so finds and removes hit
    function automatic logic [WORD_BITS-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45 && list_len > 0)
            return list_words[$urandom_range(0, list_len - 1)];
        if (r < 60)
            return $urandom_range(0, 7);
        if (r < 65)
            return {1'b1, {(WORD_BITS-1){1'b0}}};
        if (r < 70)
            return {1'b0, {(WORD_BITS-1){1'b1}}};
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_op(input mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 3'($urandom_range(FIRST_UNUSED_OP, LAST_UNUSED_OP));
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                if (r < 40) return OP_INS_FRONT;
                if (r < 70) return OP_APPEND;
                if (r < 80) return OP_FIND;
                if (r < 90) return OP_READ;
                return OP_REMOVE;
            end
            MIX_DRAIN: begin
                if (r < 12) return OP_INS_FRONT;
                if (r < 24) return OP_APPEND;
                if (r < 38) return OP_FIND;
                if (r < 52) return OP_READ;
                return OP_REMOVE;
            end
            default: begin
                if (r < 25) return OP_INS_FRONT;
                if (r < 45) return OP_APPEND;
                if (r < 65) return OP_FIND;
                if (r < 80) return OP_READ;
                return OP_REMOVE;
            end
        endcase
    endfunction

    function automatic logic [4:0] pick_position();
        if ($urandom_range(0, 99) < 80)
            return 5'($urandom_range(0, list_len + 1));
        return 5'($urandom_range(0, 31));
    endfunction

    // empty list corners, extreme words, duplicates, unused codes
    task automatic test_directed_cases();
        logic [WORD_BITS-1:0] w_min;
        logic [WORD_BITS-1:0] w_max;
        w_min = {1'b1, {(WORD_BITS-1){1'b0}}};
        w_max = {1'b0, {(WORD_BITS-1){1'b1}}};
        send_item(OP_READ, '0, 5'd0);
        send_item(OP_REMOVE, '0, 5'd0);
        send_item(OP_FIND, '0, 5'd0);
        send_item(OP_APPEND, w_min, 5'd0);
        send_item(OP_INS_FRONT, w_max, 5'd0);
        send_item(OP_APPEND, '1, 5'd0);
        send_item(OP_APPEND, w_max, 5'd0);
        send_item(OP_FIND, w_max, 5'd0);
        send_item(OP_FIND, w_min, 5'd0);
        send_item(OP_READ, '0, 5'd0);
        send_item(OP_READ, '0, 5'd4);
        send_item(OP_READ, '0, 5'd5);
        send_item(OP_READ, '1, 5'd31);
        send_item(OP_REMOVE, w_max, 5'd0);
        send_item(OP_FIND, w_max, 5'd0);
        send_item(OP_REMOVE, 32'd12345, 5'd0);
        send_item(FIRST_UNUSED_OP, w_max, 5'd1);
        send_item(FIRST_UNUSED_OP + 3'd1, '1, 5'd16);
        send_item(LAST_UNUSED_OP, w_min, 5'd31);
        send_item(OP_REMOVE, '1, 5'd0);
        send_item(OP_REMOVE, w_min, 5'd0);
        send_item(OP_REMOVE, w_max, 5'd0);
        send_item(OP_READ, '0, 5'd1);
    endtask

    // fill to capacity, then push past it and read the last slot
    task automatic test_full_list();
        while (list_len < DEPTH)
            send_item($urandom_range(0, 1) ? OP_APPEND : OP_INS_FRONT, pick_value(), 5'd0);
        send_item(OP_INS_FRONT, $urandom, 5'd0);
        send_item(OP_APPEND, $urandom, 5'd0);
        send_item(OP_READ, '0, 5'(DEPTH));
        send_item(OP_READ, '0, 5'(DEPTH + 1));
        send_item(OP_FIND, list_words[DEPTH-1], 5'd0);
        send_item(OP_REMOVE, list_words[DEPTH-1], 5'd0);
    endtask

    // random phases that swing the list between empty and full
    task automatic test_random_mix(input int n_items);
        mix_t mix;
        int   k;
        mix = MIX_BALANCED;
        for (k = 0; k < n_items; k++) begin
            if (k % 64 == 0) begin
                mix          = mix_t'($urandom_range(0, 2));
                gaps_on      = ($urandom_range(0, 99) < 75);
                ready_idling = ($urandom_range(0, 99) < 75);
            end
            send_item(pick_op(mix), pick_value(), pick_position());
        end
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_output_backpressure();
        int k;
        gaps_on      = 1'b0;
        hold_off_req = 1'b1;
        for (k = 0; k < 40; k++)
            send_item(pick_op(MIX_BALANCED), pick_value(), pick_position());
        wait_for_results();
        gaps_on = 1'b1;
    endtask

    // result monitor
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                error_count++;
                if (report_count < MAX_REPORTS) begin
                    report_count++;
                    $display("%0t: result with nothing expected: %p", $realtime, m_item);
                end
            end else begin
                want = expected_results.pop_front();
                if (m_item.status !== want.status || m_item.found_index !== want.found_index
                    || m_item.read_data !== want.read_data || m_item.count !== want.count
                    || m_item.empty_res !== want.empty_res) begin
                    error_count++;
                    if (report_count < MAX_REPORTS) begin
                        report_count++;
                        $display("%0t: mismatch expected %p", $realtime, want);
                        $display("%0t:          actual   %p", $realtime, m_item);
                    end
                end
            end
        end
    end

    // result ready: random stalls, long hold-off on request
    initial begin : ready_gen
        int r;
        int len;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else if (!ready_idling) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_ready <= 1'b1;
                    len = $urandom_range(1, 8);
                end else if (r < 95) begin
                    m_ready <= 1'b0;
                    len = $urandom_range(1, 3);
                end else begin
                    m_ready <= 1'b0;
                    len = $urandom_range(10, 40);
                end
                repeat (len) @(posedge aclk);
            end
        end
    end

    initial begin : main
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_item  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_full_list();
        test_random_mix(900);
        test_output_backpressure();
        test_random_mix(1000);
        wait_for_results();

        if (error_count == 0)
            $display("bounded_array_list_core_test: clean");
        else
            $display("bounded_array_list_core_test: errors");
        $finish;
    end

    // run limit
    initial begin : watchdog
        #10_000_000;
        $display("bounded_array_list_core_test: errors");
        $finish;
    end

endmodule
